// File: design/ahse_pkg.sv
// shared types and constants for the audio header size estimator
// no dependencies; every other design file refers to it by scoped names
`timescale 1ns / 1ps
`default_nettype none

package ahse_pkg;

    localparam int HEAD_BYTES_DEF = 4096;

    // chunk and file ids, big-endian as they appear in the byte stream
    localparam logic [31:0] ID_RIFF = 32'h52494646;
    localparam logic [31:0] ID_WAVE = 32'h57415645;
    localparam logic [31:0] ID_FMT  = 32'h666D7420;
    localparam logic [31:0] ID_DATA = 32'h64617461;
    localparam logic [31:0] ID_FLAC = 32'h664C6143;
    localparam logic [31:0] ID_FORM = 32'h464F524D;
    localparam logic [31:0] ID_COMM = 32'h434F4D4D;

    localparam logic [7:0] FLAC_CHAN_MASK  = 8'h07;
    localparam logic [7:0] FLAC_TOTAL_MASK = 8'h0F;

    localparam int DIV_STEPS = 32;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

    localparam logic [40:0] OUT_MAX = '1;

    typedef struct packed {
        logic [7:0]  head_byte;
        logic        last_byte;
        logic [39:0] file_length;
    } t_in_beat;

    typedef struct packed {
        logic [40:0] decoded_bytes;
        logic [1:0]  format_kind;
    } t_out_beat;

    typedef enum logic [1:0] {
        KIND_WAV      = 2'd0,
        KIND_FLAC     = 2'd1,
        KIND_AIFF     = 2'd2,
        KIND_FALLBACK = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        TAG_NONE = 2'd0,
        TAG_RIFF = 2'd1,
        TAG_FLAC = 2'd2,
        TAG_FORM = 2'd3
    } t_tag;

    typedef enum logic [2:0] {
        ST_HEAD,
        ST_DIV,
        ST_MUL,
        ST_FIN,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic take;
        logic div_start;
        logic mul_en;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        t_kind fin_kind;
        logic  div_last;
    } t_status;

endpackage

`default_nettype wire

// File: design/ahse_div.sv
// iterative restoring divider, one quotient bit per clock
// depends on ahse_pkg for the step count
`timescale 1ns / 1ps
`default_nettype none

module ahse_div (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [31:0] i_dividend,
    input  wire logic [12:0] i_divisor,
    output logic             o_last,
    output logic [31:0]      o_quotient
);

    logic                           r_busy;
    logic [ahse_pkg::DIV_CNT_W-1:0] r_cnt;
    logic [12:0]                    r_rem;
    logic [31:0]                    r_quo;
    logic [12:0]                    r_dvs;

    logic [13:0] rem_sh;
    logic [13:0] diff;
    logic        ge;

    assign rem_sh = {r_rem, r_quo[31]};
    assign ge     = rem_sh >= {1'b0, r_dvs};
    assign diff   = rem_sh - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= ahse_pkg::DIV_CNT_W'(ahse_pkg::DIV_STEPS);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == ahse_pkg::DIV_CNT_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= ge ? diff[12:0] : rem_sh[12:0];
            r_quo <= {r_quo[30:0], ge};
        end
    end

    assign o_last     = r_busy && (r_cnt == ahse_pkg::DIV_CNT_W'(1));
    assign o_quotient = r_quo;

endmodule

`default_nettype wire

// File: design/ahse_datapath.sv
// header parse registers, chunk walk, fmt slots, multiplier and result register
// depends on ahse_pkg and ahse_div
`timescale 1ns / 1ps
`default_nettype none

module ahse_datapath #(
    parameter int HEAD_BYTES = ahse_pkg::HEAD_BYTES_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire ahse_pkg::t_in_beat  i_in,
    input  wire ahse_pkg::t_cmd      i_cmd,
    output ahse_pkg::t_status        o_status,
    output ahse_pkg::t_out_beat      o_out
);

    localparam int CNT_W  = $clog2(HEAD_BYTES + 1);
    localparam int POS_W  = 34;
    localparam int SLOTS  = 4;
    localparam int SLOT_W = $clog2(SLOTS);

    localparam logic [1:0] CLS_OTHER = 2'd0;
    localparam logic [1:0] CLS_HIT   = 2'd1;
    localparam logic [1:0] CLS_DATA  = 2'd2;

    localparam logic [1:0] COMM_IDLE = 2'd0;
    localparam logic [1:0] COMM_WAIT = 2'd1;
    localparam logic [1:0] COMM_DONE = 2'd2;

    function automatic logic [31:0] swap32(input logic [31:0] v);
        return {v[7:0], v[15:8], v[23:16], v[31:24]};
    endfunction

    // parse state
    logic [CNT_W-1:0]   r_byte_count, n_byte_count;
    ahse_pkg::t_tag     r_tag, n_tag;
    logic [31:0]        r_recent, n_recent;
    logic [POS_W-1:0]   r_next_pos, n_next_pos;
    logic [15:0]        r_chan, n_chan;
    logic [15:0]        r_sbits, n_sbits;
    logic [31:0]        r_data_len, n_data_len;
    logic [35:0]        r_frames, n_frames;
    logic               r_walk_done, n_walk_done;
    logic [1:0]         r_class, n_class;
    logic [POS_W-1:0]   r_slot_base [SLOTS];
    logic [POS_W-1:0]   n_slot_base [SLOTS];
    logic               r_slot_live [SLOTS];
    logic               n_slot_live [SLOTS];
    logic [15:0]        r_slot_chan [SLOTS];
    logic [15:0]        n_slot_chan [SLOTS];
    logic [SLOT_W-1:0]  r_slot_next, n_slot_next;
    logic [POS_W-1:0]   r_comm_base, n_comm_base;
    logic [1:0]         r_comm_stage, n_comm_stage;

    // result side
    ahse_pkg::t_kind    r_kind;
    logic [35:0]        r_mul_a;
    logic [15:0]        r_mul_b;
    logic [51:0]        r_prod;
    logic [40:0]        r_flen2;
    ahse_pkg::t_out_beat r_out;

    logic [POS_W:0]     pos_i;
    logic [POS_W:0]     pos_p3;
    logic [POS_W:0]     pos_p7;
    logic [31:0]        recent_in;
    logic [31:0]        chunk_size;
    logic [POS_W-1:0]   pos_skip;
    logic [15:0]        le2;
    logic               in_range;
    logic               fin;
    ahse_pkg::t_kind    fin_kind;
    logic [31:0]        quotient;
    logic               div_last;
    logic [53:0]        prod4;
    logic [40:0]        result;

    assign in_range   = r_byte_count < CNT_W'(HEAD_BYTES);
    assign fin        = i_cmd.take && i_in.last_byte;
    assign pos_i      = (POS_W + 1)'(r_byte_count);
    assign pos_p3     = {1'b0, r_next_pos} + (POS_W + 1)'(3);
    assign pos_p7     = {1'b0, r_next_pos} + (POS_W + 1)'(7);
    // last four bytes including the one on the input
    assign recent_in  = {r_recent[23:0], i_in.head_byte};
    assign le2        = {recent_in[7:0], recent_in[15:8]};
    // the tag is settled by the time the walk starts at byte 12
    assign chunk_size = (r_tag == ahse_pkg::TAG_RIFF) ? swap32(recent_in) : recent_in;
    assign pos_skip   = r_next_pos + POS_W'(chunk_size) + POS_W'(8) + POS_W'(chunk_size[0]);

    // absorb one head byte
    always_comb begin
        n_byte_count = r_byte_count;
        n_tag        = r_tag;
        n_recent     = r_recent;
        n_next_pos   = r_next_pos;
        n_chan       = r_chan;
        n_sbits      = r_sbits;
        n_data_len   = r_data_len;
        n_frames     = r_frames;
        n_walk_done  = r_walk_done;
        n_class      = r_class;
        n_slot_next  = r_slot_next;
        n_comm_base  = r_comm_base;
        n_comm_stage = r_comm_stage;
        for (int k = 0; k < SLOTS; k++) begin
            n_slot_base[k] = r_slot_base[k];
            n_slot_live[k] = r_slot_live[k];
            n_slot_chan[k] = r_slot_chan[k];
        end

        if (i_cmd.take && in_range) begin
            n_byte_count = r_byte_count + 1'b1;
            n_recent     = recent_in;

            if (r_byte_count == CNT_W'(3)) begin
                case (n_recent)
                    ahse_pkg::ID_RIFF: n_tag = ahse_pkg::TAG_RIFF;
                    ahse_pkg::ID_FLAC: n_tag = ahse_pkg::TAG_FLAC;
                    ahse_pkg::ID_FORM: n_tag = ahse_pkg::TAG_FORM;
                    default:           n_tag = ahse_pkg::TAG_NONE;
                endcase
            end
            if (r_byte_count == CNT_W'(11) && n_tag == ahse_pkg::TAG_RIFF
                    && n_recent != ahse_pkg::ID_WAVE) begin
                n_tag = ahse_pkg::TAG_NONE;
            end

            // streaminfo fields, offset past the block header
            if (n_tag == ahse_pkg::TAG_FLAC) begin
                if (r_byte_count == CNT_W'(20)) begin
                    n_chan = 16'((i_in.head_byte >> 1) & ahse_pkg::FLAC_CHAN_MASK) + 16'd1;
                end else if (r_byte_count == CNT_W'(21)) begin
                    n_frames = 36'(i_in.head_byte & ahse_pkg::FLAC_TOTAL_MASK);
                end else if (r_byte_count >= CNT_W'(22) && r_byte_count <= CNT_W'(25)) begin
                    n_frames = {r_frames[27:0], i_in.head_byte};
                end
            end

            // chunk walk
            if ((n_tag == ahse_pkg::TAG_RIFF || n_tag == ahse_pkg::TAG_FORM)
                    && r_byte_count >= CNT_W'(12) && !r_walk_done) begin
                if (pos_i == pos_p3) begin
                    if (n_tag == ahse_pkg::TAG_RIFF) begin
                        if (n_recent == ahse_pkg::ID_FMT) begin
                            n_class = CLS_HIT;
                        end else if (n_recent == ahse_pkg::ID_DATA) begin
                            n_class = CLS_DATA;
                        end else begin
                            n_class = CLS_OTHER;
                        end
                    end else begin
                        n_class = (n_recent == ahse_pkg::ID_COMM) ? CLS_HIT : CLS_OTHER;
                    end
                end else if (pos_i == pos_p7) begin
                    if (n_tag == ahse_pkg::TAG_RIFF && r_class == CLS_DATA) begin
                        n_data_len  = chunk_size;
                        n_walk_done = 1'b1;
                    end else if (n_tag == ahse_pkg::TAG_FORM && r_class == CLS_HIT) begin
                        n_comm_base  = r_next_pos;
                        n_comm_stage = COMM_WAIT;
                        n_walk_done  = 1'b1;
                    end else begin
                        if (n_tag == ahse_pkg::TAG_RIFF && r_class == CLS_HIT) begin
                            n_slot_base[r_slot_next] = r_next_pos;
                            n_slot_live[r_slot_next] = 1'b1;
                            n_slot_chan[r_slot_next] = '0;
                            n_slot_next              = r_slot_next + 1'b1;
                        end
                        n_next_pos = pos_skip;
                    end
                end
            end

            // fmt capture: channels at offset 10, bits per sample at offset 22
            if (n_tag == ahse_pkg::TAG_RIFF) begin
                for (int k = 0; k < SLOTS; k++) begin
                    if (n_slot_live[k]) begin
                        if (pos_i == {1'b0, n_slot_base[k]} + (POS_W + 1)'(11)) begin
                            n_slot_chan[k] = le2;
                        end
                        if (pos_i == {1'b0, n_slot_base[k]} + (POS_W + 1)'(23)) begin
                            n_chan         = n_slot_chan[k];
                            n_sbits        = le2;
                            n_slot_live[k] = 1'b0;
                        end
                    end
                end
            end

            // comm capture, big-endian
            if (n_tag == ahse_pkg::TAG_FORM && n_comm_stage == COMM_WAIT) begin
                if (pos_i == {1'b0, r_comm_base} + (POS_W + 1)'(9)) begin
                    n_chan = n_recent[15:0];
                end
                if (pos_i == {1'b0, r_comm_base} + (POS_W + 1)'(13)) begin
                    n_frames     = 36'(n_recent);
                    n_comm_stage = COMM_DONE;
                end
            end
        end
    end

    // estimate kind for a head that ends with this byte
    always_comb begin
        fin_kind = ahse_pkg::KIND_FALLBACK;
        if (n_tag == ahse_pkg::TAG_RIFF && n_byte_count >= CNT_W'(12)) begin
            if (n_chan != '0 && n_sbits >= 16'd8 && n_data_len != '0) begin
                fin_kind = ahse_pkg::KIND_WAV;
            end
        end else if (n_tag == ahse_pkg::TAG_FLAC && n_byte_count >= CNT_W'(42)) begin
            if (n_frames != '0) begin
                fin_kind = ahse_pkg::KIND_FLAC;
            end
        end else if (n_tag == ahse_pkg::TAG_FORM && n_byte_count >= CNT_W'(12)) begin
            if (n_comm_stage == COMM_DONE && n_chan != '0 && n_frames != '0) begin
                fin_kind = ahse_pkg::KIND_AIFF;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || fin) begin
            r_byte_count <= '0;
            r_tag        <= ahse_pkg::TAG_NONE;
            r_recent     <= '0;
            r_next_pos   <= POS_W'(12);
            r_chan       <= '0;
            r_sbits      <= '0;
            r_data_len   <= '0;
            r_frames     <= '0;
            r_walk_done  <= 1'b0;
            r_class      <= CLS_OTHER;
            r_slot_next  <= '0;
            r_comm_base  <= '0;
            r_comm_stage <= COMM_IDLE;
            for (int k = 0; k < SLOTS; k++) begin
                r_slot_live[k] <= 1'b0;
            end
        end else begin
            r_byte_count <= n_byte_count;
            r_tag        <= n_tag;
            r_recent     <= n_recent;
            r_next_pos   <= n_next_pos;
            r_chan       <= n_chan;
            r_sbits      <= n_sbits;
            r_data_len   <= n_data_len;
            r_frames     <= n_frames;
            r_walk_done  <= n_walk_done;
            r_class      <= n_class;
            r_slot_next  <= n_slot_next;
            r_comm_base  <= n_comm_base;
            r_comm_stage <= n_comm_stage;
            for (int k = 0; k < SLOTS; k++) begin
                r_slot_live[k] <= n_slot_live[k];
            end
        end
    end

    // slot base and channel are only read while the slot is live
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < SLOTS; k++) begin
            r_slot_base[k] <= n_slot_base[k];
            r_slot_chan[k] <= n_slot_chan[k];
        end
    end

    // operands held for the result phase
    always_ff @(posedge i_clk) begin
        if (fin) begin
            r_kind  <= fin_kind;
            r_mul_a <= n_frames;
            r_mul_b <= n_chan;
            r_flen2 <= {i_in.file_length, 1'b0};
        end
        if (i_cmd.mul_en) begin
            r_prod <= r_mul_a * r_mul_b;
        end
        if (i_cmd.load_out) begin
            r_out.decoded_bytes <= result;
            r_out.format_kind   <= r_kind;
        end
    end

    ahse_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (n_data_len),
        .i_divisor  (n_sbits[15:3]),
        .o_last     (div_last),
        .o_quotient (quotient)
    );

    assign prod4 = {r_prod, 2'b00};

    always_comb begin
        case (r_kind)
            ahse_pkg::KIND_WAV: begin
                result = {7'd0, quotient, 2'b00};
            end
            ahse_pkg::KIND_FLAC, ahse_pkg::KIND_AIFF: begin
                result = (|prod4[53:41]) ? ahse_pkg::OUT_MAX : prod4[40:0];
            end
            default: begin
                result = r_flen2;
            end
        endcase
    end

    assign o_status.fin_kind = fin_kind;
    assign o_status.div_last = div_last;
    assign o_out             = r_out;

endmodule

`default_nettype wire

// File: design/ahse_ctrl.sv
// sequencing state machine: byte intake, divide or multiply, result beat
// depends on ahse_pkg
`timescale 1ns / 1ps
`default_nettype none

module ahse_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    input  wire logic              i_last_byte,
    input  wire logic              i_out_ready,
    input  wire ahse_pkg::t_status i_status,
    output logic                   o_in_ready,
    output logic                   o_out_valid,
    output ahse_pkg::t_cmd         o_cmd
);

    ahse_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ahse_pkg::ST_HEAD;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        o_cmd       = '0;

        case (r_state)
            ahse_pkg::ST_HEAD: begin
                o_in_ready = 1'b1;
            end
            ahse_pkg::ST_DIV: begin
                if (i_status.div_last) begin
                    n_state = ahse_pkg::ST_FIN;
                end
            end
            ahse_pkg::ST_MUL: begin
                o_cmd.mul_en = 1'b1;
                n_state      = ahse_pkg::ST_FIN;
            end
            ahse_pkg::ST_FIN: begin
                o_cmd.load_out = 1'b1;
                n_state        = ahse_pkg::ST_OUT;
            end
            ahse_pkg::ST_OUT: begin
                o_out_valid = 1'b1;
                o_in_ready  = i_out_ready;
                if (i_out_ready) begin
                    n_state = ahse_pkg::ST_HEAD;
                end
            end
            default: begin
                n_state = ahse_pkg::ST_HEAD;
            end
        endcase

        o_cmd.take = i_in_valid && o_in_ready;
        if (o_cmd.take && i_last_byte) begin
            case (i_status.fin_kind)
                ahse_pkg::KIND_WAV: begin
                    o_cmd.div_start = 1'b1;
                    n_state         = ahse_pkg::ST_DIV;
                end
                ahse_pkg::KIND_FLAC, ahse_pkg::KIND_AIFF: begin
                    n_state = ahse_pkg::ST_MUL;
                end
                default: begin
                    n_state = ahse_pkg::ST_FIN;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// File: design/audio_header_size_estimate.sv
// after the last byte of a head is taken, the controller goes through ST_FIN for the fallback,
// ST_MUL and ST_FIN for flac and aiff (one multiply), or ST_DIV (32-step divider) and ST_FIN
// for wav, and o_out_valid rises in ST_OUT, where the result beat waits for its handshake
// throughput: one byte per cycle during the head, one head at a time through the result phase
// reset: synchronous active-low i_rst_n clears the parser, the controller and o_out_valid
// the parse state also clears itself when the last byte of a head is taken
`timescale 1ns / 1ps
`default_nettype none

module audio_header_size_estimate #(
    parameter int HEAD_BYTES = ahse_pkg::HEAD_BYTES_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    // head byte channel
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    input  wire ahse_pkg::t_in_beat  i_in_data,
    // estimate channel
    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    output ahse_pkg::t_out_beat      o_out_data
);

    // command and status between the controller and the datapath
    ahse_pkg::t_cmd    cmd;
    ahse_pkg::t_status status;

    // controller: takes bytes while in the head phase, then sequences the
    // divider (wav), the multiplier (flac, aiff) or neither (fallback),
    // loads the output register and holds the result beat until taken.
    // a new head may start in the same cycle that the result beat leaves
    ahse_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_last_byte (i_in_data.last_byte),
        .i_out_ready (i_out_ready),
        .i_status    (status),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .o_cmd       (cmd)
    );

    // datapath: byte counter compares drive the chunk walk; fmt fields go
    // through four capture slots so overlapping fmt chunks are tracked.
    // on the last byte the estimate kind is decided from the updated
    // state, the operands are held and the parse state returns to reset
    ahse_datapath #(
        .HEAD_BYTES (HEAD_BYTES)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in_data),
        .i_cmd    (cmd),
        .o_status (status),
        .o_out    (o_out_data)
    );

endmodule

`default_nettype wire

// File: design/ahse_checker.sv
// port-level checks for the audio header size estimator, bound to the top level
// depends on ahse_pkg and audio_header_size_estimate
`timescale 1ns / 1ps
`default_nettype none

module ahse_checker (
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                i_in_valid,
    input wire logic                o_in_ready,
    input wire ahse_pkg::t_in_beat  i_in_data,
    input wire logic                o_out_valid,
    input wire logic                i_out_ready,
    input wire ahse_pkg::t_out_beat o_out_data
);

    // a stalled result beat keeps its value
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result beat changed while stalled");

    // no new head byte is taken while a result waits
    a_no_intake_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |-> !o_in_ready)
        else $error("byte taken while result stalled");

    // wav estimate is the sample count x 4
    a_wav_mult4: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.format_kind == ahse_pkg::KIND_WAV
        |-> o_out_data.decoded_bytes[1:0] == 2'b00)
        else $error("wav estimate not a multiple of four");

    // fallback estimate is file length x 2
    a_fallback_even: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.format_kind == ahse_pkg::KIND_FALLBACK
        |-> !o_out_data.decoded_bytes[0])
        else $error("fallback estimate is odd");

    // flac and aiff are a multiple of four unless saturated
    a_mul_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.format_kind == ahse_pkg::KIND_FLAC
            || o_out_data.format_kind == ahse_pkg::KIND_AIFF)
        |-> o_out_data.decoded_bytes[1:0] == 2'b00
            || o_out_data.decoded_bytes == ahse_pkg::OUT_MAX)
        else $error("product estimate malformed");

endmodule

bind audio_header_size_estimate ahse_checker u_ahse_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

`default_nettype wire

// File: dv/audio_header_size_checker.sv
// estimate checker for audio_header_size_estimate: tracks the parse of each head and
// checks every estimate beat in order; depends on ahse_pkg for the beat types and ids
`timescale 1ns / 1ps

module audio_header_size_checker #(
    parameter int HEAD_BYTES = ahse_pkg::HEAD_BYTES_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_ready,
    input  ahse_pkg::t_in_beat  i_in_data,
    input  logic                i_out_valid,
    input  logic                i_out_ready,
    input  ahse_pkg::t_out_beat i_out_data,
    output int                  o_fail_count,
    output int                  o_pending
);

    import ahse_pkg::*;

    typedef enum logic [1:0] {
        CHUNK_OTHER,
        CHUNK_INFO,
        CHUNK_DATA
    } t_chunk;

    typedef enum logic [1:0] {
        COMM_IDLE,
        COMM_OPEN,
        COMM_DONE
    } t_comm;

    // parse state of the head in flight
    int unsigned byte_idx;
    t_tag        tag;
    logic [31:0] recent;
    logic [63:0] chunk_pos;
    logic [31:0] n_chan;
    logic [31:0] n_width;
    logic [31:0] data_len;
    logic [63:0] n_frames;
    logic        walk_done;
    t_chunk      chunk_kind;
    logic [63:0] fmt_base [4];
    logic        fmt_live [4];
    logic [31:0] fmt_chan [4];
    logic [1:0]  fmt_next;
    logic [63:0] comm_base;
    t_comm       comm_stage;

    t_out_beat est_q [$];
    int        mismatches = 0;

    assign o_fail_count = mismatches;

    function automatic void clear_parse();
        byte_idx   = 0;
        tag        = TAG_NONE;
        recent     = '0;
        chunk_pos  = 64'd12;
        n_chan     = '0;
        n_width    = '0;
        data_len   = '0;
        n_frames   = '0;
        walk_done  = 1'b0;
        chunk_kind = CHUNK_OTHER;
        for (int k = 0; k < 4; k++) begin
            fmt_base[k] = '0;
            fmt_live[k] = 1'b0;
            fmt_chan[k] = '0;
        end
        fmt_next   = '0;
        comm_base  = '0;
        comm_stage = COMM_IDLE;
    endfunction

    function automatic logic [63:0] clip_est(input logic [63:0] v);
        return (v > 64'(OUT_MAX)) ? 64'(OUT_MAX) : v;
    endfunction

    // chunk walk: id at pos..pos+3, size at pos+4..pos+7
    function automatic void walk_chunk(input logic [63:0] idx);
        logic [31:0] clen;
        clen = (tag == TAG_RIFF) ? {recent[7:0], recent[15:8], recent[23:16], recent[31:24]}
                                 : recent;
        if (idx == chunk_pos + 3) begin
            if (tag == TAG_RIFF)
                chunk_kind = (recent == ID_FMT)  ? CHUNK_INFO :
                             (recent == ID_DATA) ? CHUNK_DATA : CHUNK_OTHER;
            else
                chunk_kind = (recent == ID_COMM) ? CHUNK_INFO : CHUNK_OTHER;
        end else if (idx == chunk_pos + 7) begin
            if (tag == TAG_RIFF && chunk_kind == CHUNK_DATA) begin
                data_len  = clen;
                walk_done = 1'b1;
            end else if (tag == TAG_FORM && chunk_kind == CHUNK_INFO) begin
                comm_base  = chunk_pos;
                comm_stage = COMM_OPEN;
                walk_done  = 1'b1;
            end else begin
                if (tag == TAG_RIFF && chunk_kind == CHUNK_INFO) begin
                    fmt_base[fmt_next] = chunk_pos;
                    fmt_live[fmt_next] = 1'b1;
                    fmt_chan[fmt_next] = '0;
                    fmt_next++;
                end
                // odd sizes carry one pad byte
                chunk_pos = chunk_pos + 64'd8 + 64'(clen) + 64'(clen[0]);
            end
        end
    endfunction

    function automatic void take_byte(input logic [63:0] idx, input logic [7:0] b);
        logic [31:0] pair_le;
        recent  = {recent[23:0], b};
        pair_le = {16'd0, recent[7:0], recent[15:8]};
        if (idx == 3)
            tag = (recent == ID_RIFF) ? TAG_RIFF :
                  (recent == ID_FLAC) ? TAG_FLAC :
                  (recent == ID_FORM) ? TAG_FORM : TAG_NONE;
        if (idx == 11 && tag == TAG_RIFF && recent != ID_WAVE)
            tag = TAG_NONE;
        if (tag == TAG_FLAC) begin
            if (idx == 20)
                n_chan = 32'((b >> 1) & FLAC_CHAN_MASK) + 32'd1;
            else if (idx == 21)
                n_frames = 64'(b & FLAC_TOTAL_MASK);
            else if (idx >= 22 && idx <= 25)
                n_frames = {n_frames[55:0], b};
        end
        if ((tag == TAG_RIFF || tag == TAG_FORM) && idx >= 12 && !walk_done)
            walk_chunk(idx);
        if (tag == TAG_RIFF) begin
            for (int k = 0; k < 4; k++) begin
                if (fmt_live[k]) begin
                    if (idx == fmt_base[k] + 11)
                        fmt_chan[k] = pair_le;
                    if (idx == fmt_base[k] + 23) begin
                        n_chan      = fmt_chan[k];
                        n_width     = pair_le;
                        fmt_live[k] = 1'b0;
                    end
                end
            end
        end
        if (tag == TAG_FORM && comm_stage == COMM_OPEN) begin
            if (idx == comm_base + 9)
                n_chan = {16'd0, recent[15:0]};
            if (idx == comm_base + 13) begin
                n_frames   = 64'(recent);
                comm_stage = COMM_DONE;
            end
        end
    endfunction

    function automatic void predict_beat(input t_in_beat bt);
        logic [63:0] est;
        t_kind       kind;
        t_out_beat   exp_beat;
        est  = {23'd0, bt.file_length, 1'b0};
        kind = KIND_FALLBACK;
        // bytes past the head window are dropped, the last mark still counts
        if (byte_idx < HEAD_BYTES) begin
            byte_idx++;
            take_byte(64'(byte_idx - 1), bt.head_byte);
        end
        if (bt.last_byte) begin
            if (tag == TAG_RIFF && byte_idx >= 12) begin
                if (n_chan != 0 && n_width >= 8 && data_len != 0) begin
                    est  = {32'd0, data_len / (n_width >> 3)} << 2;
                    kind = KIND_WAV;
                end
            end else if (tag == TAG_FLAC && byte_idx >= 42) begin
                if (n_frames != 0) begin
                    est  = clip_est(n_frames * 64'(n_chan) * 64'd4);
                    kind = KIND_FLAC;
                end
            end else if (tag == TAG_FORM && byte_idx >= 12) begin
                if (comm_stage == COMM_DONE && n_chan != 0 && n_frames != 0) begin
                    est  = clip_est(n_frames * 64'(n_chan) * 64'd4);
                    kind = KIND_AIFF;
                end
            end
            exp_beat.decoded_bytes = est[40:0];
            exp_beat.format_kind   = kind;
            est_q.insert(est_q.size(), exp_beat);
            clear_parse();
        end
    endfunction

    function automatic void check_estimate(input t_out_beat got);
        t_out_beat exp_beat;
        if (est_q.size() == 0) begin
            mismatches++;
            $display("%0t: estimate beat with none outstanding: expected none, got %0d kind %0d",
                     $time, got.decoded_bytes, got.format_kind);
        end else begin
            exp_beat = est_q.pop_front();
            if (got.decoded_bytes !== exp_beat.decoded_bytes) begin
                mismatches++;
                $display("%0t: decoded_bytes expected %0d got %0d",
                         $time, exp_beat.decoded_bytes, got.decoded_bytes);
            end
            if (got.format_kind !== exp_beat.format_kind) begin
                mismatches++;
                $display("%0t: format_kind expected %0d got %0d",
                         $time, exp_beat.format_kind, got.format_kind);
            end
        end
    endfunction

    // estimate beat first: it can never belong to a byte taken on the same edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_parse();
            est_q.delete();
        end else begin
            if (i_out_valid && i_out_ready)
                check_estimate(i_out_data);
            if (i_in_valid && i_in_ready)
                predict_beat(i_in_data);
        end
        o_pending <= est_q.size();
    end

endmodule

// File: dv/testbench.sv
// top of the audio_header_size_estimate bench: byte stimulus, estimate sink and verdict
// depends on ahse_pkg, audio_header_size_estimate and audio_header_size_checker
`timescale 1ns / 1ps

module testbench;

    import ahse_pkg::*;

    localparam int ITEMS     = 1850;  // head bytes to offer in all
    // slowest clean run: ~1850 bytes with random gaps, ~50 estimates, two long sink stalls;
    // the limit is far above that
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int HOLD_CYCLES = 400;
    localparam int HOLD_FIRST  = 4;
    localparam int HOLD_SECOND = 30;
    localparam int DRAIN_CYCLES = 60;  // longer than a full divide
    localparam logic [31:0] ID_AIFF = 32'h41494646;

    logic      clk;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_ready;
    t_in_beat  in_data   = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    t_out_beat out_data;

    int fail_count;
    int pending;

    // stimulus bookkeeping
    logic [7:0] head_q [$];
    bit         tx_steady = 1'b0;
    int         bytes_sent = 0;
    int         cycle_cnt = 0;

    audio_header_size_estimate u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    audio_header_size_checker u_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_data   (out_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ---------------- head builders ----------------

    // append one byte at the tail of the head
    function automatic void add_byte(input logic [7:0] b);
        head_q.insert(head_q.size(), b);
    endfunction

    function automatic void put_be32(input logic [31:0] v);
        for (int s = 3; s >= 0; s--) add_byte(v[8*s +: 8]);
    endfunction

    function automatic void put_le32(input logic [31:0] v);
        for (int s = 0; s < 4; s++) add_byte(v[8*s +: 8]);
    endfunction

    function automatic void put_noise(input int n);
        repeat (n) add_byte(8'($urandom()));
    endfunction

    // one whole chunk with random body, padded to even length
    function automatic void put_chunk(input logic [31:0] id, input logic [31:0] len, input bit le);
        put_be32(id);
        if (le)
            put_le32(len);
        else
            put_be32(len);
        put_noise(int'(len) + int'(len[0]));
    endfunction

    function automatic void trim_head(input int n);
        while (head_q.size() > n) void'(head_q.pop_back());
    endfunction

    // values with the extremes well represented
    function automatic logic [31:0] pick32();
        case ($urandom_range(0, 5))
            0: return 32'd0;
            1: return '1;
            2: return $urandom_range(1, 16);
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [15:0] pick_width();
        case ($urandom_range(0, 5))
            0: return 16'd0;
            1: return 16'($urandom_range(1, 7));
            2: return 16'd8;
            3: return 16'd16;
            4: return ($urandom_range(0, 1) == 0) ? 16'd24 : 16'd32;
            default: return 16'($urandom());
        endcase
    endfunction

    function automatic logic [39:0] pick_len();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            default: return {8'($urandom()), 32'($urandom())};
        endcase
    endfunction

    // RIFF/WAVE: optional leading chunks (some of them short fmt chunks), fmt, then data
    function automatic void build_wav(input logic [15:0] chans, input logic [15:0] width,
                                      input logic [31:0] dlen, input int junk, input int fmt_len);
        head_q.delete();
        put_be32(ID_RIFF);
        put_le32($urandom());
        put_be32(ID_WAVE);
        repeat (junk)
            put_chunk(($urandom_range(0, 2) == 0) ? ID_FMT : $urandom(), $urandom_range(0, 9), 1'b1);
        put_be32(ID_FMT);
        put_le32(fmt_len);
        // channels at body offset 2, sample width at body offset 14, both little-endian
        for (int k = 0; k < fmt_len + fmt_len % 2; k++) begin
            case (k)
                2:       add_byte(chans[7:0]);
                3:       add_byte(chans[15:8]);
                14:      add_byte(width[7:0]);
                15:      add_byte(width[15:8]);
                default: add_byte(8'($urandom()));
            endcase
        end
        put_be32(ID_DATA);
        put_le32(dlen);
        put_noise($urandom_range(0, 6));
    endfunction

    // fLaC + block header + STREAMINFO; channels in byte 20, sample total in 21..25
    function automatic void build_flac(input logic [7:0] chan_byte, input logic [35:0] frames,
                                       input int len);
        head_q.delete();
        put_be32(ID_FLAC);
        put_noise((len > 26) ? len - 4 : 22);
        head_q[20] = chan_byte;
        head_q[21] = {4'($urandom()), frames[35:32]};
        head_q[22] = frames[31:24];
        head_q[23] = frames[23:16];
        head_q[24] = frames[15:8];
        head_q[25] = frames[7:0];
        trim_head(len);
    endfunction

    // FORM with big-endian chunks ahead of COMM; form type is not always AIFF
    function automatic void build_aiff(input logic [15:0] chans, input logic [31:0] frames,
                                       input int junk);
        head_q.delete();
        put_be32(ID_FORM);
        put_be32($urandom());
        put_be32(($urandom_range(0, 3) == 0) ? $urandom() : ID_AIFF);
        repeat (junk) put_chunk($urandom(), $urandom_range(0, 9), 1'b0);
        put_be32(ID_COMM);
        put_be32(32'd18);
        add_byte(chans[15:8]);
        add_byte(chans[7:0]);
        put_be32(frames);
        put_noise(12 + $urandom_range(0, 8));
    endfunction

    // ---------------- byte sender ----------------

    // offers head_q beat by beat; the last beat carries the file length
    task automatic send_head(input logic [39:0] flen);
        int gap;
        for (int k = 0; k < head_q.size(); k++) begin
            gap = tx_steady ? 0 : $urandom_range(0, 12);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            in_valid <= 1'b1;
            in_data  <= '{head_byte:   head_q[k],
                          last_byte:   (k == head_q.size() - 1),
                          file_length: (k == head_q.size() - 1) ? flen : pick_len()};
            do @(posedge clk); while (in_ready !== 1'b1);
        end
        bytes_sent += head_q.size();
    endtask

    // ---------------- estimate sink ----------------

    // random stalls per beat, calm stretches, and two long holds that back up the input
    initial begin : sink
        int gap;
        int taken;
        bit rx_steady;
        taken     = 0;
        rx_steady = 1'b0;
        while (rst_n !== 1'b1) @(posedge clk);
        forever begin
            if (taken == HOLD_FIRST || taken == HOLD_SECOND) begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            gap = rx_steady ? 0 : $urandom_range(0, 12);
            if (gap > 0) begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (out_valid !== 1'b1);
            taken++;
            if ($urandom_range(0, 7) == 0)
                rx_steady = !rx_steady;
        end
    end

    // ---------------- watchdog ----------------

    initial begin : watchdog
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_cnt++;
        end
        $display("audio_header_size_estimate: mismatch");
        $finish;
    end

    // ---------------- main sequence ----------------

    initial begin : stimulus
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // one-byte heads: fallback at both ends of the file length
        head_q.delete();
        add_byte(8'h00);
        send_head('1);
        head_q.delete();
        add_byte(8'hFF);
        send_head('0);

        // plain wav, then the narrow and zero sample widths that must fall back
        build_wav(16'd2, 16'd16, 32'd1000, 0, 16);
        send_head(pick_len());
        build_wav(16'd1, 16'd4, 32'd500, 0, 16);
        send_head(pick_len());
        build_wav(16'd2, 16'd0, 32'd500, 0, 16);
        send_head(pick_len());
        // leading chunks with pad bytes, widest data size, no channels
        build_wav(16'hFFFF, 16'd8, '1, 2, 18);
        send_head(pick_len());
        build_wav(16'd0, 16'd16, 32'd64, 0, 16);
        send_head(pick_len());
        // RIFF that is not WAVE, and a head shorter than the RIFF header
        build_wav(16'd2, 16'd16, 32'd1000, 0, 16);
        head_q[8] = 8'h41;
        send_head(pick_len());
        build_wav(16'd2, 16'd16, 32'd1000, 0, 16);
        trim_head(11);
        send_head(pick_len());

        // flac: largest estimate, empty total, one byte short, exactly long enough
        build_flac(8'hFF, '1, 42);
        send_head(pick_len());
        build_flac(8'h00, 36'd0, 50);
        send_head(pick_len());
        build_flac(8'h0E, 36'd12345, 41);
        send_head(pick_len());
        build_flac(8'h0E, 36'd12345, 42);
        send_head(pick_len());

        // aiff: plain, saturating, cut before the frame count ends, no channels
        build_aiff(16'd2, 32'd44100, 1);
        send_head(pick_len());
        build_aiff('1, '1, 0);
        send_head(pick_len());
        build_aiff(16'd2, 32'd100, 0);
        trim_head(25);
        send_head(pick_len());
        build_aiff(16'd0, 32'd100, 0);
        send_head(pick_len());

        // random heads, mostly well formed with random fields
        while (bytes_sent < ITEMS) begin
            tx_steady = ($urandom_range(0, 3) == 0);
            case ($urandom_range(0, 9))
                0, 1, 2: build_wav(16'(pick32()), pick_width(), pick32(), $urandom_range(0, 3),
                                   ($urandom_range(0, 3) == 0) ? $urandom_range(0, 40) : 16);
                3, 4:    build_flac(8'($urandom()), {4'($urandom()), pick32()},
                                    ($urandom_range(0, 4) == 0) ? $urandom_range(1, 41)
                                                                : $urandom_range(42, 60));
                5, 6:    build_aiff(16'(pick32()), pick32(), $urandom_range(0, 3));
                default: begin
                    // noise, sometimes behind a real file id
                    head_q.delete();
                    case ($urandom_range(0, 3))
                        0: put_be32(ID_RIFF);
                        1: put_be32(ID_FLAC);
                        2: put_be32(ID_FORM);
                        default: put_be32($urandom());
                    endcase
                    put_noise($urandom_range(0, 56));
                end
            endcase
            // broken sequences: a stray byte or an early end
            if ($urandom_range(0, 7) == 0)
                head_q[$urandom_range(0, head_q.size() - 1)] = 8'($urandom());
            if ($urandom_range(0, 7) == 0)
                trim_head($urandom_range(1, head_q.size()));
            send_head(pick_len());
        end
        in_valid <= 1'b0;

        // drain: every estimate in, then a quiet stretch
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("audio_header_size_estimate: match");
        else
            $display("audio_header_size_estimate: mismatch");
        $finish;
    end

endmodule

// File: audio_header_size_estimate.f
design/ahse_pkg.sv
design/ahse_div.sv
design/ahse_datapath.sv
design/ahse_ctrl.sv
design/audio_header_size_estimate.sv
design/ahse_checker.sv
dv/audio_header_size_checker.sv
dv/testbench.sv
